[sv/bts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bts_pkg
// Types, codes and helpers shared by the tone symbol encoder modules.
// ----------------------------------------------------------------------------
package bts_pkg;

    // Mode register codes
    localparam logic [2:0] MODE_THREE = 3'd0;
    localparam logic [2:0] MODE_TWO   = 3'd1;
    localparam logic [2:0] MODE_ONE   = 3'd2;
    localparam logic [2:0] MODE_DIFF  = 3'd3;
    localparam logic [2:0] MODE_VOTE  = 3'd4;

    // Register indexes on the configuration port
    localparam logic REG_MODE     = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    // Register reset values
    localparam logic [2:0] MODE_RESET     = MODE_THREE;
    localparam logic [3:0] CAPACITY_RESET = 4'd9;

    // Run lengths per encoding
    localparam logic [3:0] RUN_THREE  = 4'd3;
    localparam logic [3:0] RUN_TWO    = 4'd4;
    localparam logic [3:0] RUN_ONE    = 4'd8;
    localparam logic [3:0] RUN_DIFF   = 4'd9;
    localparam logic [3:0] RUN_VOTE   = 4'd9;
    localparam logic [3:0] RUN_REJECT = 4'd1;

    // Differential encoding levels
    localparam logic [2:0] DIFF_START = 3'd2;
    localparam logic [2:0] DIFF_TOP   = 3'd5;

    // Job queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_THREE,
        KIND_TWO,
        KIND_ONE,
        KIND_DIFF,
        KIND_VOTE,
        KIND_REJECT
    } kind_t;

    // One classified byte waiting for the back end
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } job_t;

    // Number of results a job of this kind produces
    function automatic logic [3:0] run_len(input kind_t kind);
        logic [3:0] len;
        case (kind)
            KIND_THREE: len = RUN_THREE;
            KIND_TWO:   len = RUN_TWO;
            KIND_ONE:   len = RUN_ONE;
            KIND_DIFF:  len = RUN_DIFF;
            KIND_VOTE:  len = RUN_VOTE;
            default:    len = RUN_REJECT;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

[sv/bts_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bts_front
// Holds the configuration registers and classifies each incoming byte into a
// job: its encoding kind, or a reject for an unknown mode or low capacity.
// ----------------------------------------------------------------------------
module bts_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [3:0]    cfg_wdata,
    input  wire logic [7:0]    in_byte,
    output bts_pkg::job_t      job
);

    logic [2:0] mode_reg;
    logic [3:0] capacity_reg;
    bts_pkg::kind_t kind_sel;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= bts_pkg::MODE_RESET;
            capacity_reg <= bts_pkg::CAPACITY_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                bts_pkg::REG_MODE:     mode_reg     <= cfg_wdata[2:0];
                bts_pkg::REG_CAPACITY: capacity_reg <= cfg_wdata;
                default:               mode_reg     <= mode_reg;
            endcase
        end
    end

    // Map mode to kind, reject unknown modes
    always_comb begin
        case (mode_reg)
            bts_pkg::MODE_THREE: kind_sel = bts_pkg::KIND_THREE;
            bts_pkg::MODE_TWO:   kind_sel = bts_pkg::KIND_TWO;
            bts_pkg::MODE_ONE:   kind_sel = bts_pkg::KIND_ONE;
            bts_pkg::MODE_DIFF:  kind_sel = bts_pkg::KIND_DIFF;
            bts_pkg::MODE_VOTE:  kind_sel = bts_pkg::KIND_VOTE;
            default:             kind_sel = bts_pkg::KIND_REJECT;
        endcase
    end

    // Reject unknown modes, or runs that do not fit the consumer's capacity
    always_comb begin
        job.data = in_byte;
        if (kind_sel == bts_pkg::KIND_REJECT
                || capacity_reg < bts_pkg::run_len(kind_sel)) begin
            job.kind = bts_pkg::KIND_REJECT;
        end else begin
            job.kind = kind_sel;
        end
    end

endmodule
`default_nettype wire

[sv/bts_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bts_queue
// Short job queue that decouples byte intake from symbol output.
// ----------------------------------------------------------------------------
module bts_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire bts_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output bts_pkg::job_t      head_job
);

    localparam int DEPTH = bts_pkg::QUEUE_DEPTH;
    localparam int PTR_W = bts_pkg::QUEUE_PTR_W;
    localparam int CNT_W = bts_pkg::QUEUE_CNT_W;

    bts_pkg::job_t entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entries[rd_ptr_reg];

    // Store pushed jobs
    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/bts_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bts_back
// Steps through each job's run, one symbol per unstalled cycle, into an
// output register; a waiting job starts in the next unstalled cycle.
// ----------------------------------------------------------------------------
module bts_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          head_valid,
    input  wire bts_pkg::job_t head_job,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [2:0]         m_symbol,
    output logic [3:0]         m_position,
    output logic               m_last,
    output logic               m_rejected
);

    logic          busy_reg, busy_next;
    bts_pkg::job_t job_reg, job_next;
    logic [3:0]    pos_reg, pos_next;
    logic [2:0]    cur_reg, cur_next;
    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_symbol_reg, m_symbol_next;
    logic [3:0]    m_position_reg, m_position_next;
    logic          m_last_reg, m_last_next;
    logic          m_rejected_reg, m_rejected_next;

    bts_pkg::job_t src;
    logic [3:0]    idx;
    logic [2:0]    prev;
    logic [2:0]    sym;
    logic          is_last;
    logic          out_free;

    // Pick one of the three chunks of a byte
    function automatic logic [2:0] chunk(input logic [7:0] data, input logic [1:0] c);
        logic [2:0] r;
        case (c)
            2'd0:    r = data[7:5];
            2'd1:    r = data[4:2];
            default: r = {data[1:0], 1'b0};
        endcase
        return r;
    endfunction

    // Symbol at index i of a job's run
    function automatic logic [2:0] calc_symbol(input bts_pkg::kind_t kind,
                                               input logic [7:0] data,
                                               input logic [3:0] i,
                                               input logic [2:0] lvl);
        logic [2:0] r;
        logic [3:0] bidx;
        logic [1:0] c;
        bidx = 4'd8 - i;
        c    = (i < 4'd3) ? 2'd0 : ((i < 4'd6) ? 2'd1 : 2'd2);
        case (kind)
            bts_pkg::KIND_THREE: r = chunk(data, i[1:0]);
            bts_pkg::KIND_VOTE:  r = chunk(data, c);
            bts_pkg::KIND_TWO: begin
                case (i[1:0])
                    2'd0:    r = {1'b0, data[7:6]};
                    2'd1:    r = {1'b0, data[5:4]};
                    2'd2:    r = {1'b0, data[3:2]};
                    default: r = {1'b0, data[1:0]};
                endcase
            end
            bts_pkg::KIND_ONE:   r = {2'b00, data[3'd7 - i[2:0]]};
            bts_pkg::KIND_DIFF: begin
                if (i == 4'd0) begin
                    r = bts_pkg::DIFF_START;
                end else if (data[bidx[2:0]]) begin
                    r = (lvl < bts_pkg::DIFF_TOP) ? lvl + 3'd1 : lvl;
                end else begin
                    r = (lvl > 3'd0) ? lvl - 3'd1 : lvl;
                end
            end
            default:             r = 3'd0;
        endcase
        return r;
    endfunction

    // Select the running job, or the queue head when idle
    always_comb begin
        src      = busy_reg ? job_reg : head_job;
        idx      = busy_reg ? pos_reg : 4'd0;
        prev     = busy_reg ? cur_reg : bts_pkg::DIFF_START;
        sym      = calc_symbol(src.kind, src.data, idx, prev);
        is_last  = ((idx + 4'd1) == bts_pkg::run_len(src.kind));
        out_free = !m_valid_reg || m_ready;
        pop      = out_free && !busy_reg && head_valid;
    end

    // Emit one symbol per free output slot
    always_comb begin
        busy_next       = busy_reg;
        job_next        = job_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        m_valid_next    = m_valid_reg;
        m_symbol_next   = m_symbol_reg;
        m_position_next = m_position_reg;
        m_last_next     = m_last_reg;
        m_rejected_next = m_rejected_reg;
        if (out_free) begin
            if (busy_reg || head_valid) begin
                m_valid_next    = 1'b1;
                m_symbol_next   = sym;
                m_position_next = idx;
                m_last_next     = is_last;
                m_rejected_next = (src.kind == bts_pkg::KIND_REJECT);
                job_next        = src;
                busy_next       = !is_last;
                pos_next        = idx + 4'd1;
                cur_next        = sym;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        job_reg        <= job_next;
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        m_symbol_reg   <= m_symbol_next;
        m_position_reg <= m_position_next;
        m_last_reg     <= m_last_next;
        m_rejected_reg <= m_rejected_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_symbol   = m_symbol_reg;
    assign m_position = m_position_reg;
    assign m_last     = m_last_reg;
    assign m_rejected = m_rejected_reg;

endmodule
`default_nettype wire

[sv/byte_to_tone_symbol_encoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_to_tone_symbol_encoder
// Turns each input byte into a run of tone symbol indices.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one data byte per transfer. The m_ channel gives one
//   result per symbol: tdata holds symbol and position, tlast marks the end
//   of the byte's run, tuser flags a rejected byte (one result, all zero).
//   Run length is 3, 4, 8, 9 or 9 results for modes 0 to 4; a byte is
//   rejected when the mode is unknown or the capacity register is below the
//   run length.
//   Configuration writes (mode, capacity) are taken at any edge with cfg_we
//   and should be made while no byte is in flight.
//   A byte passes through the queue, and its first result through the output
//   register, before that result can leave. The back end's symbol counter
//   gives one result per cycle while the receiver does not stall, one per
//   run position (a single one for a reject), and runs follow each other
//   without a gap. A two-entry job queue lets input be taken while a run is
//   still leaving.
//   Reset clears the queue and the output valid flag and restores mode 0 and
//   capacity 9. When the receiver stalls, the output register holds and the
//   queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module byte_to_tone_symbol_encoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Configuration
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [3:0] cfg_wdata,
    // Input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    // Result stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [2:0] symbol, [6:3] position, [7] zero
    output logic            m_tlast,   // last
    output logic            m_tuser    // rejected
);

    bts_pkg::job_t front_job;
    bts_pkg::job_t head_job;
    logic          queue_full;
    logic          head_valid;
    logic          pop;
    logic          push;
    logic [2:0]    symbol;
    logic [3:0]    position;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    bts_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_byte   (s_tdata),
        .job       (front_job)
    );

    bts_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (front_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    bts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_symbol   (symbol),
        .m_position (position),
        .m_last     (m_tlast),
        .m_rejected (m_tuser)
    );

    assign m_tdata = {1'b0, position, symbol};

endmodule
`default_nettype wire

[sv/bts_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bts_checker
// Port-level checks on the result stream of the tone symbol encoder.
// ----------------------------------------------------------------------------
module bts_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result changed");

    // Rejected result is a lone all-zero last
    a_reject_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
        else $error("malformed rejected result");

    // Position never passes the longest run, and its end closes the run
    a_position_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[6:3] >= 4'd8) |-> (m_tdata[6:3] == 4'd8) && m_tlast)
        else $error("position beyond run end");

endmodule

bind byte_to_tone_symbol_encoder bts_checker u_bts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
